// ===== src/su2sp_pkg.sv =====
// ----------------------------------------------------------------------------
// su2sp_pkg
// shared types, widths, codes and small lookup functions for the su(2)
// subgroup projection block
// ----------------------------------------------------------------------------
`default_nettype none

package su2sp_pkg;

    localparam int ELEM_W = 18;
    localparam int COEF_W = 19;
    localparam int UNIT_W = 18;
    localparam int SG_W   = 2;
    localparam int CNT_W  = 4;
    localparam int SQ_W   = 2 * COEF_W;
    localparam int SUM_W  = 40;
    localparam int ROOT_W = SUM_W / 2;
    localparam int MAG_W  = COEF_W;
    localparam int QDEPTH = 2;

    localparam logic [CNT_W-1:0] LAST_ELEM = CNT_W'(8);

    // subgroup codes
    localparam logic [SG_W-1:0] SG_ROWS12     = 2'd0;
    localparam logic [SG_W-1:0] SG_ROWS02     = 2'd1;
    localparam logic [SG_W-1:0] SG_ROWS01     = 2'd2;
    localparam logic [SG_W-1:0] SG_ROWS01_ALT = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
    } coef_set_t;

    typedef struct packed {
        logic hit;
        logic pos;
    } pair_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_ROOT,
        BK_DSETUP,
        BK_DIVIDE,
        BK_FINISH
    } back_state_t;

    function automatic logic [1:0] elem_row(input logic [CNT_W-1:0] e);
        logic [1:0] r;
        priority if (e < CNT_W'(3)) r = 2'd0;
        else if (e < CNT_W'(6))     r = 2'd1;
        else                        r = 2'd2;
        return r;
    endfunction

    function automatic logic [1:0] elem_col(input logic [CNT_W-1:0] e);
        logic [1:0] c;
        unique case (e)
            CNT_W'(0), CNT_W'(3), CNT_W'(6): c = 2'd0;
            CNT_W'(1), CNT_W'(4), CNT_W'(7): c = 2'd1;
            default:                         c = 2'd2;
        endcase
        return c;
    endfunction

    // place of a row or column index inside the chosen pair
    function automatic pair_t pair_pos(input logic [SG_W-1:0] sg, input logic [1:0] k);
        logic [1:0] lo;
        logic [1:0] hi;
        pair_t      p;
        lo = (sg == SG_ROWS12) ? 2'd1 : 2'd0;
        hi = (sg == SG_ROWS01 || sg == SG_ROWS01_ALT) ? 2'd1 : 2'd2;
        priority if (k == lo) p = '{hit: 1'b1, pos: 1'b0};
        else if (k == hi)     p = '{hit: 1'b1, pos: 1'b1};
        else                  p = '{hit: 1'b0, pos: 1'b0};
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/su2sp_front.sv =====
// ----------------------------------------------------------------------------
// su2sp_front
// takes matrix elements, keeps the chosen 2x2 submatrix and forms the four
// raw coefficients after the ninth element
// ----------------------------------------------------------------------------
`default_nettype none

module su2sp_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [su2sp_pkg::ELEM_W-1:0] elem_re,
    input  wire logic signed [su2sp_pkg::ELEM_W-1:0] elem_im,
    input  wire logic [su2sp_pkg::SG_W-1:0]        subgroup,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output su2sp_pkg::coef_set_t                   push_data
);
    import su2sp_pkg::*;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [SG_W-1:0]          sg_reg;
    logic [SG_W-1:0]          sg_next;
    logic signed [ELEM_W-1:0] sub_re_reg [4];
    logic signed [ELEM_W-1:0] sub_im_reg [4];
    logic signed [ELEM_W-1:0] sub_re_next [4];
    logic signed [ELEM_W-1:0] sub_im_next [4];

    logic [CNT_W-1:0] e;
    logic [SG_W-1:0]  sg_cur;
    logic             is_last;
    logic             accept;
    pair_t            rp;
    pair_t            cp;
    logic             wr_en;
    logic [1:0]       wr_idx;

    assign e       = (count_reg >= LAST_ELEM) ? LAST_ELEM : count_reg;
    assign sg_cur  = (e == '0) ? subgroup : sg_reg;
    assign is_last = (e == LAST_ELEM);
    assign in_ready = !is_last || push_ready;
    assign accept  = in_valid && in_ready;

    assign rp     = pair_pos(sg_cur, elem_row(e));
    assign cp     = pair_pos(sg_cur, elem_col(e));
    assign wr_en  = accept && rp.hit && cp.hit;
    assign wr_idx = {rp.pos, cp.pos};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sub_re_next[k] = sub_re_reg[k];
            sub_im_next[k] = sub_im_reg[k];
        end
        if (wr_en)
        begin
            sub_re_next[wr_idx] = elem_re;
            sub_im_next[wr_idx] = elem_im;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sg_next    = sg_reg;
        if (accept)
        begin
            count_next = is_last ? '0 : e + CNT_W'(1);
            if (e == '0)
            begin
                sg_next = subgroup;
            end
        end
    end

    // coefficients include the ninth element when it lands in the submatrix
    assign push_valid   = accept && is_last;
    assign push_data.a0 = COEF_W'(sub_re_next[0]) + COEF_W'(sub_re_next[3]);
    assign push_data.a1 = COEF_W'(sub_im_next[1]) + COEF_W'(sub_im_next[2]);
    assign push_data.a2 = COEF_W'(sub_re_next[1]) - COEF_W'(sub_re_next[2]);
    assign push_data.a3 = COEF_W'(sub_im_next[0]) - COEF_W'(sub_im_next[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sg_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sg_reg    <= sg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            sub_re_reg[k] <= sub_re_next[k];
            sub_im_reg[k] <= sub_im_next[k];
        end
    end

endmodule

`default_nettype wire

// ===== src/su2sp_queue.sv =====
// ----------------------------------------------------------------------------
// su2sp_queue
// short queue of coefficient sets between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module su2sp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire su2sp_pkg::coef_set_t push_data,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output su2sp_pkg::coef_set_t      pop_data
);
    import su2sp_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int FILL_W = $clog2(QDEPTH + 1);

    coef_set_t          mem [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (fill_reg != FILL_W'(QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/su2sp_back.sv =====
// ----------------------------------------------------------------------------
// su2sp_back
// sum of squares, iterative integer square root and four parallel
// restoring dividers that scale the coefficients to unit length
// ----------------------------------------------------------------------------
`default_nettype none

module su2sp_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pop_valid,
    output logic                                   pop_ready,
    input  wire su2sp_pkg::coef_set_t              pop_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a0,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a1,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a2,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a3,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a0,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a1,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a2,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a3,
    output logic                                   zero_norm
);
    import su2sp_pkg::*;

    localparam int QW     = FRAC_BITS + 1;
    localparam int DW     = FRAC_BITS + MAG_W + 1;
    localparam int DREM_W = ROOT_W + 1;
    localparam int RREM_W = ROOT_W + 2;
    localparam int UW     = (FRAC_BITS + 2 > UNIT_W) ? FRAC_BITS + 2 : UNIT_W;
    localparam int ITER_W = $clog2(QW + ROOT_W + 1);
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    back_state_t state_reg;
    back_state_t state_next;

    logic [ITER_W-1:0]       iter_reg;
    coef_set_t               a_reg;
    logic [SQ_W-1:0]         prod_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [RREM_W-1:0]       rrem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic                    zero_reg;
    logic [DREM_W-1:0]       drem_reg [4];
    logic [QW-1:0]           dlow_reg [4];
    logic [QW-1:0]           quo_reg  [4];
    logic                    out_valid_reg;
    logic signed [COEF_W-1:0] out_coef_reg [4];
    logic signed [UNIT_W-1:0] out_unit_reg [4];
    logic                    out_zero_reg;

    logic signed [COEF_W-1:0] a_arr [4];
    logic signed [SQ_W-1:0]   sq;
    logic [RREM_W-1:0]        rr_sh;
    logic [RREM_W-1:0]        trial;
    logic                     root_bit;
    logic [MAG_W-1:0]         mag [4];
    logic [DW-1:0]            dvd [4];
    logic [DREM_W-1:0]        dt  [4];
    logic                     dbit [4];
    logic signed [UNIT_W-1:0] unit_val [4];
    logic                     sq_last;
    logic                     root_last;
    logic                     div_last;
    logic                     load_out;

    assign a_arr[0] = a_reg.a0;
    assign a_arr[1] = a_reg.a1;
    assign a_arr[2] = a_reg.a2;
    assign a_arr[3] = a_reg.a3;

    assign sq = a_arr[iter_reg[1:0]] * a_arr[iter_reg[1:0]];

    assign rr_sh    = {rrem_reg[RREM_W-3:0], sum_reg[SUM_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign root_bit = (rr_sh >= trial);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [UW-1:0] qs;
            mag[k]  = a_arr[k][COEF_W-1] ? MAG_W'(-a_arr[k]) : MAG_W'(a_arr[k]);
            dvd[k]  = (DW'(mag[k]) << FRAC_BITS) + DW'(root_reg >> 1);
            dt[k]   = {drem_reg[k][DREM_W-2:0], dlow_reg[k][QW-1]};
            dbit[k] = (dt[k] >= DREM_W'(root_reg));
            qs = UW'((quo_reg[k] > ONE_Q) ? ONE_Q : quo_reg[k]);
            if (a_arr[k][COEF_W-1])
            begin
                qs = -qs;
            end
            unit_val[k] = zero_reg ? '0 : qs[UNIT_W-1:0];
        end
    end

    assign sq_last   = (iter_reg == ITER_W'(4));
    assign root_last = (iter_reg == ITER_W'(ROOT_W - 1));
    assign div_last  = (iter_reg == ITER_W'(QW - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                if (sq_last)
                begin
                    state_next = BK_ROOT;
                end
            end
            BK_ROOT:
            begin
                if (root_last)
                begin
                    state_next = BK_DSETUP;
                end
            end
            BK_DSETUP:
            begin
                state_next = (root_reg == '0) ? BK_FINISH : BK_DIVIDE;
            end
            BK_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = (state_reg == BK_IDLE);
        load_out  = (state_reg == BK_FINISH) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                a_reg    <= pop_data;
                iter_reg <= '0;
                sum_reg  <= '0;
            end
            BK_SQUARE:
            begin
                if (!sq_last)
                begin
                    prod_reg <= SQ_W'(sq);
                end
                if (iter_reg != '0)
                begin
                    sum_reg <= sum_reg + SUM_W'(prod_reg);
                end
                iter_reg <= sq_last ? '0 : iter_reg + ITER_W'(1);
                rrem_reg <= '0;
                root_reg <= '0;
            end
            BK_ROOT:
            begin
                rrem_reg <= root_bit ? rr_sh - trial : rr_sh;
                root_reg <= {root_reg[ROOT_W-2:0], root_bit};
                sum_reg  <= sum_reg << 2;
                iter_reg <= root_last ? '0 : iter_reg + ITER_W'(1);
            end
            BK_DSETUP:
            begin
                zero_reg <= (root_reg == '0);
                iter_reg <= '0;
                for (int k = 0; k < 4; k++)
                begin
                    drem_reg[k] <= DREM_W'(dvd[k][DW-1:QW]);
                    dlow_reg[k] <= dvd[k][QW-1:0];
                    quo_reg[k]  <= '0;
                end
            end
            BK_DIVIDE:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    drem_reg[k] <= dbit[k] ? dt[k] - DREM_W'(root_reg) : dt[k];
                    dlow_reg[k] <= dlow_reg[k] << 1;
                    quo_reg[k]  <= {quo_reg[k][QW-2:0], dbit[k]};
                end
                iter_reg <= iter_reg + ITER_W'(1);
            end
            BK_FINISH:
            begin
                if (load_out)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        out_coef_reg[k] <= a_arr[k];
                        out_unit_reg[k] <= unit_val[k];
                    end
                    out_zero_reg <= zero_reg;
                end
            end
            default:
            begin
                iter_reg <= '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign coef_a0   = out_coef_reg[0];
    assign coef_a1   = out_coef_reg[1];
    assign coef_a2   = out_coef_reg[2];
    assign coef_a3   = out_coef_reg[3];
    assign unit_a0   = out_unit_reg[0];
    assign unit_a1   = out_unit_reg[1];
    assign unit_a2   = out_unit_reg[2];
    assign unit_a3   = out_unit_reg[3];
    assign zero_norm = out_zero_reg;

endmodule

`default_nettype wire

// ===== src/su2_subgroup_project_unit.sv =====
// ----------------------------------------------------------------------------
// su2_subgroup_project_unit
// su(2) subgroup projection of a 3x3 complex matrix streamed in row-major
// ----------------------------------------------------------------------------
// elements are taken one per cycle while in_ready is high; a full matrix needs nine transfers
// after the ninth element the back end loads the set, squares and sums the
// coefficients, runs 20 root steps and a setup step, then, unless the root is zero,
// FRAC_BITS + 1 divide steps, and registers the result once the output is free;
// no new set is taken until then; a two-deep queue lets the front load meanwhile
// reset clears counters, queue and state; submatrix storage is not cleared
`default_nettype none

module su2_subgroup_project_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [su2sp_pkg::ELEM_W-1:0] elem_re,
    input  wire logic signed [su2sp_pkg::ELEM_W-1:0] elem_im,
    input  wire logic [su2sp_pkg::SG_W-1:0]        subgroup,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a0,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a1,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a2,
    output logic signed [su2sp_pkg::COEF_W-1:0]    coef_a3,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a0,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a1,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a2,
    output logic signed [su2sp_pkg::UNIT_W-1:0]    unit_a3,
    output logic                                   zero_norm
);
    import su2sp_pkg::*;

    logic      push_valid;
    logic      push_ready;
    coef_set_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    coef_set_t pop_data;

    su2sp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elem_re    (elem_re),
        .elem_im    (elem_im),
        .subgroup   (subgroup),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    su2sp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    su2sp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .coef_a0   (coef_a0),
        .coef_a1   (coef_a1),
        .coef_a2   (coef_a2),
        .coef_a3   (coef_a3),
        .unit_a0   (unit_a0),
        .unit_a1   (unit_a1),
        .unit_a2   (unit_a2),
        .unit_a3   (unit_a3),
        .zero_norm (zero_norm)
    );

endmodule

`default_nettype wire

// ===== src/su2sp_checker.sv =====
// ----------------------------------------------------------------------------
// su2sp_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module su2sp_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic signed [su2sp_pkg::COEF_W-1:0] coef_a0,
    input  wire logic signed [su2sp_pkg::COEF_W-1:0] coef_a1,
    input  wire logic signed [su2sp_pkg::COEF_W-1:0] coef_a2,
    input  wire logic signed [su2sp_pkg::COEF_W-1:0] coef_a3,
    input  wire logic signed [su2sp_pkg::UNIT_W-1:0] unit_a0,
    input  wire logic signed [su2sp_pkg::UNIT_W-1:0] unit_a1,
    input  wire logic signed [su2sp_pkg::UNIT_W-1:0] unit_a2,
    input  wire logic signed [su2sp_pkg::UNIT_W-1:0] unit_a3,
    input  wire logic                              zero_norm
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its coefficients
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(coef_a0) && $stable(coef_a1)
            && $stable(coef_a2) && $stable(coef_a3) && $stable(zero_norm))
        else $error("result changed while stalled");

    // zero norm gives zero unit vector
    a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> unit_a0 == '0 && unit_a1 == '0
            && unit_a2 == '0 && unit_a3 == '0)
        else $error("nonzero unit with zero norm");

    // zero norm flag matches the coefficients
    a_zero_coefs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> zero_norm == (coef_a0 == '0 && coef_a1 == '0
            && coef_a2 == '0 && coef_a3 == '0))
        else $error("zero norm flag disagrees with coefficients");

endmodule

bind su2_subgroup_project_unit su2sp_checker u_su2sp_checker (.*);

`default_nettype wire

// ===== test/su2_subgroup_project_unit_tb.sv =====
// ----------------------------------------------------------------------------
// su2_subgroup_project_unit_tb
// streams 3x3 complex matrices through the su(2) subgroup projection unit
// ----------------------------------------------------------------------------
// each element transfer feeds a matrix tracker that keeps the chosen 2x2
// submatrix and, on the ninth element, computes the raw coefficients, the
// integer norm and the rounded unit coefficients; results are compared field
// by field in order. directed matrices hit the range limits, every subgroup
// code and the zero norm case, then random matrices run with random idle
// gaps on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module su2_subgroup_project_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import su2sp_pkg::*;

    localparam int FRAC        = 16;
    localparam int HOLD_CYCLES = 500;
    localparam int REPORT_MAX  = 50;

    typedef struct packed {
        logic [3:0][COEF_W-1:0] coef;
        logic [3:0][UNIT_W-1:0] norm_unit;
        logic                   zero;
    } projection_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [ELEM_W-1:0] elem_re = '0;
    logic signed [ELEM_W-1:0] elem_im = '0;
    logic [SG_W-1:0]          subgroup = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [COEF_W-1:0] coef_a0, coef_a1, coef_a2, coef_a3;
    logic signed [UNIT_W-1:0] unit_a0, unit_a1, unit_a2, unit_a3;
    logic                     zero_norm;

    // matrix tracker state
    int          elem_pos = 0;
    logic [1:0]  held_sg = '0;
    int          kept_re [4];
    int          kept_im [4];
    projection_t pending_projections [$];

    bit          sender_idles = 1'b1;
    bit          drain_stalls = 1'b1;
    int          hold_request = 0;
    int          mismatch_count = 0;
    int          elements_sent = 0;
    int          results_checked = 0;
    int          zero_norm_results = 0;
    logic [3:0]  sg_seen = '0;

    su2_subgroup_project_unit #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elem_re   (elem_re),
        .elem_im   (elem_im),
        .subgroup  (subgroup),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .coef_a0   (coef_a0),
        .coef_a1   (coef_a1),
        .coef_a2   (coef_a2),
        .coef_a3   (coef_a3),
        .unit_a0   (unit_a0),
        .unit_a1   (unit_a1),
        .unit_a2   (unit_a2),
        .unit_a3   (unit_a3),
        .zero_norm (zero_norm)
    );

    always #4 clk = ~clk;

    function automatic void pick_pair(input logic [1:0] sg, output int lo, output int hi);
        lo = (sg == SG_ROWS12) ? 1 : 0;
        hi = (sg == SG_ROWS01 || sg == SG_ROWS01_ALT) ? 1 : 2;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned probe;
        r = 0;
        probe = 64'd1 << 40;
        while (probe > x)
            probe >>= 2;
        while (probe != 0)
        begin
            if (x >= r + probe)
            begin
                x -= r + probe;
                r = (r >> 1) + probe;
            end
            else
                r >>= 1;
            probe >>= 2;
        end
        return r;
    endfunction

    // round half away from zero, saturate at one
    function automatic logic [UNIT_W-1:0] unit_share(input int a, input longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = longint'((a < 0) ? -a : a);
        q = ((mag << FRAC) + (root >> 1)) / root;
        if (q > (64'd1 << FRAC))
            q = 64'd1 << FRAC;
        if (a < 0)
            q = 64'd0 - q;
        return q[UNIT_W-1:0];
    endfunction

    task automatic track_element(input logic signed [ELEM_W-1:0] re,
                                 input logic signed [ELEM_W-1:0] im,
                                 input logic [SG_W-1:0] sg);
        int              lo, hi, rp, cp, row, col;
        int              a [4];
        longint unsigned sum;
        longint unsigned root;
        projection_t     res;
        if (elem_pos == 0)
            held_sg = sg;
        pick_pair(held_sg, lo, hi);
        row = elem_pos / 3;
        col = elem_pos % 3;
        rp = (row == lo) ? 0 : (row == hi) ? 1 : -1;
        cp = (col == lo) ? 0 : (col == hi) ? 1 : -1;
        if (rp >= 0 && cp >= 0)
        begin
            kept_re[rp * 2 + cp] = int'(re);
            kept_im[rp * 2 + cp] = int'(im);
        end
        if (elem_pos < 8)
            elem_pos++;
        else
        begin
            elem_pos = 0;
            a[0] = kept_re[0] + kept_re[3];
            a[1] = kept_im[1] + kept_im[2];
            a[2] = kept_re[1] - kept_re[2];
            a[3] = kept_im[0] - kept_im[3];
            sum = 0;
            for (int k = 0; k < 4; k++)
            begin
                sum += longint'(a[k]) * longint'(a[k]);
                res.coef[k] = COEF_W'(a[k]);
            end
            res.zero = (sum == 0);
            root = (sum == 0) ? 0 : floor_sqrt(sum);
            for (int k = 0; k < 4; k++)
                res.norm_unit[k] = (sum == 0) ? '0 : unit_share(a[k], root);
            pending_projections.push_back(res);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_elem(input int kind);
        logic signed [ELEM_W-1:0] v;
        case (kind)
            6, 7: return int'($urandom_range(0, 6)) - 3;
            8: return int'($urandom_range(0, 262142)) - 131071;
            9:
            begin
                case ($urandom_range(0, 4))
                    0: return -131072;
                    1: return -1;
                    2: return 0;
                    3: return 1;
                    default: return 131071;
                endcase
            end
            default:
            begin
                v = ELEM_W'($urandom);
                return int'(v);
            end
        endcase
    endfunction

    task automatic send_element(input logic signed [ELEM_W-1:0] re,
                                input logic signed [ELEM_W-1:0] im,
                                input logic [SG_W-1:0] sg);
        int gap;
        @(negedge clk);
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        elem_re = re;
        elem_im = im;
        subgroup = sg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_element(re, im, sg);
        elements_sent++;
    endtask

    // subgroup on later elements is random, the block must ignore it
    task automatic send_matrix(input int re_v [9], input int im_v [9],
                               input logic [SG_W-1:0] sg);
        logic [SG_W-1:0] sg_now;
        sg_seen[sg] = 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            sg_now = (i == 0) ? sg : SG_W'($urandom_range(0, 3));
            send_element(ELEM_W'(re_v[i]), ELEM_W'(im_v[i]), sg_now);
        end
    endtask

    task automatic send_random_matrix();
        int              re_v [9];
        int              im_v [9];
        int              kind, lo, hi, p00, p01, p10, p11;
        logic [SG_W-1:0] sg;
        kind = $urandom_range(0, 9);
        sg = SG_W'($urandom_range(0, 3));
        for (int i = 0; i < 9; i++)
        begin
            re_v[i] = rand_elem(kind);
            im_v[i] = rand_elem(kind);
        end
        // nonzero submatrix whose coefficients all cancel
        if (kind == 8)
        begin
            pick_pair(sg, lo, hi);
            p00 = lo * 4;
            p01 = lo * 3 + hi;
            p10 = hi * 3 + lo;
            p11 = hi * 4;
            re_v[p11] = -re_v[p00];
            im_v[p11] = im_v[p00];
            re_v[p10] = re_v[p01];
            im_v[p10] = -im_v[p01];
        end
        send_matrix(re_v, im_v, sg);
    endtask

    task automatic test_directed_cases();
        int re_v [9];
        int im_v [9];
        // coefficient extremes, a2 at its top value
        re_v = '{-131072, 131071, 131071, -131072, -131072, -1, 0, 131071, -131072};
        im_v = '{-131072, 131071, -1, 131071, 131071, 0, 131071, -131072, 1};
        send_matrix(re_v, im_v, SG_ROWS01);
        // alternate code, chosen block all zero: zero norm
        re_v = '{0, 0, 131071, 0, 0, -131072, 131071, -131072, 131071};
        im_v = '{0, 0, -131072, 0, 0, 131071, -131072, 131071, -131072};
        send_matrix(re_v, im_v, SG_ROWS01_ALT);
        re_v = '{-131072, -131072, -131072, -131072, 131071, 131071, -131072, 131071, 131071};
        im_v = '{131071, 131071, 131071, 131071, -131072, -131072, 131071, -131072, -131072};
        send_matrix(re_v, im_v, SG_ROWS12);
        // single small coefficient gives a full-scale unit value
        re_v = '{-1, 131071, 0, -131072, 131071, -131072, 0, 131071, 0};
        im_v = '{0, -131072, 0, 131071, -131072, 131071, 0, -131072, 0};
        send_matrix(re_v, im_v, SG_ROWS02);
    endtask

    task automatic test_output_hold();
        sender_idles = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (6) send_random_matrix();
        sender_idles = 1'b1;
    endtask

    task automatic test_random_matrices();
        for (int m = 0; m < 155; m++)
        begin
            sender_idles = ((m / 25) % 3) != 1;
            drain_stalls = ((m / 25) % 4) != 2;
            send_random_matrix();
        end
        sender_idles = 1'b1;
        drain_stalls = 1'b1;
    endtask

    initial
    begin : drain_driver
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            else
            begin
                stall = drain_stalls ? pick_gap() : 0;
                if (stall > 0)
                begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        projection_t got;
        projection_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.coef = {coef_a3, coef_a2, coef_a1, coef_a0};
            got.norm_unit = {unit_a3, unit_a2, unit_a1, unit_a0};
            got.zero = zero_norm;
            results_checked++;
            if (got.zero)
                zero_norm_results++;
            if (pending_projections.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result transfer with none expected", $time);
            end
            else
            begin
                want = pending_projections.pop_front();
                for (int k = 0; k < 4; k++)
                begin
                    if (got.coef[k] !== want.coef[k])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: coef_a%0d expected %0d got %0d", $time, k,
                                     $signed(want.coef[k]), $signed(got.coef[k]));
                    end
                    if (got.norm_unit[k] !== want.norm_unit[k])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: unit_a%0d expected %0d got %0d", $time, k,
                                     $signed(want.norm_unit[k]), $signed(got.norm_unit[k]));
                    end
                end
                if (got.zero !== want.zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: zero_norm expected %0b got %0b", $time,
                                 want.zero, got.zero);
                end
            end
        end
    end

    initial
    begin : run_tests
        int waited;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_cases();
        test_output_hold();
        test_random_matrices();
        @(negedge clk);
        in_valid = 1'b0;
        waited = 0;
        while (pending_projections.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (pending_projections.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_projections.size());
        end
        $display("sent %0d elements; checked %0d projections, %0d of them zero norm",
                 elements_sent, results_checked, zero_norm_results);
        $display("subgroup codes used (bit per code): %b; one output hold-off of %0d cycles",
                 sg_seen, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("su2_subgroup_project_unit: match");
        else
            $display("su2_subgroup_project_unit: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("su2_subgroup_project_unit: mismatch");
        $finish;
    end

endmodule
